>>> design/rau_pkg.sv
`default_nettype none
package rau_pkg;

    localparam int DEF_WORD_BITS = 32;

    localparam logic [2:0] OP_NORM  = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_CMP   = 3'd5;
    localparam logic [2:0] OP_SPLIT = 3'd6;
    localparam logic [2:0] OP_NOP   = 3'd7;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ZERO = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;

    localparam logic [1:0] REL_LT = 2'd0;
    localparam logic [1:0] REL_EQ = 2'd1;
    localparam logic [1:0] REL_GT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_MUL1,
        ST_MUL2,
        ST_PREP,
        ST_RED_R,
        ST_SPLIT,
        ST_CHECK,
        ST_OUT
    } state_t;

    // divider request/response
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

>>> design/rau_if.sv
`default_nettype none
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [31:0] int_part;
    logic [1:0]  relation;
    logic [1:0]  error_code;
    modport source (output valid, res_num, res_den, int_part, relation, error_code,
                    input ready);
    modport sink   (input valid, res_num, res_den, int_part, relation, error_code,
                    output ready);
endinterface
`default_nettype wire

>>> design/rational_arith_unit_core.sv
`default_nettype none
// Channel  Dir  Words
// in       sink operation, a_num, a_den, b_num, b_den
// out      src  res_num, res_den, int_part, relation, error_code
//
// One word at a time; ready is low from accept until the result is taken.
// Every Euclid step and the split's division run on one bit-serial divider;
// each modulo step starts it and waits for its done.
// Reset clears control only. A stalled output holds its word.
module rational_arith_unit_core
    import rau_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    rau_in_if.sink    in_ch,
    rau_out_if.source out_ch
);
    localparam int WB = WORD_BITS;

    state_t      st_reg, st_next;
    logic [2:0]  op_reg, op_next;
    // signed 64-bit working values
    logic [63:0] an_reg, an_next, ad_reg, ad_next;
    logic [63:0] bn_reg, bn_next, bd_reg, bd_next;
    logic [63:0] rn_reg, rn_next, rd_reg, rd_next;
    logic [63:0] ip_reg, ip_next;
    // euclid pair
    logic [63:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [1:0]  gph_reg, gph_next;   // 0: gcd loop, 1: divide num, 2: divide den
    logic        dwait_reg, dwait_next;
    logic [1:0]  err_reg, err_next;
    logic [1:0]  rel_reg, rel_next;
    logic        ov_reg, ov_next;
    logic [31:0] o_num_reg, o_num_next, o_ip_reg, o_ip_next;
    logic [30:0] o_den_reg, o_den_next;

    div_req_t dreq;
    div_rsp_t drsp;

    rau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    function automatic logic [63:0] sext(input logic [31:0] v);
        logic [63:0] r;
        r = {{32{v[WB-1]}}, v};
        r = 64'(signed'(r << (64 - WB)) >>> (64 - WB));
        return r;
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    // operands of every product are reduced word-sized values
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [63:0] sn, sd;   // reduction target in RED states
    logic        red_done;
    logic [63:0] red_n, red_d;
    logic [63:0] wmax;
    assign wmax = (64'd1 << (WB - 1)) - 64'd1;

    always_comb
    begin
        st_next = st_reg; op_next = op_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        rn_next = rn_reg; rd_next = rd_reg; ip_next = ip_reg;
        ga_next = ga_reg; gb_next = gb_reg; gph_next = gph_reg;
        dwait_next = dwait_reg; err_next = err_reg; rel_next = rel_reg; ov_next = ov_reg;
        o_num_next = o_num_reg; o_den_next = o_den_reg; o_ip_next = o_ip_reg;
        dreq = '0;
        mul_a = '0; mul_b = '0;
        red_done = 1'b0; red_n = 64'd0; red_d = 64'd1;
        sn = rn_reg; sd = rd_reg;
        case (st_reg)
            ST_RED_A: begin sn = an_reg; sd = ad_reg; end
            ST_RED_B: begin sn = bn_reg; sd = bd_reg; end
            default: ;
        endcase

        // shared Euclid reduction sequence on (sn, sd) with ga/gb
        if (st_reg == ST_RED_A || st_reg == ST_RED_B || st_reg == ST_RED_R)
        begin
            if (!dwait_reg)
            begin
                if (gph_reg == 2'd0 && gb_reg == 64'd0)
                begin
                    if (ga_reg == 64'd0)
                        ga_next = 64'd1;
                    gph_next = 2'd1;
                end
                else
                begin
                    dwait_next = 1'b1;
                    dreq.start = 1'b1;
                    case (gph_reg)
                        2'd0:    begin dreq.dividend = ga_reg; dreq.divisor = gb_reg; end
                        2'd1:    begin dreq.dividend = mag(sn); dreq.divisor = ga_reg; end
                        default: begin dreq.dividend = sd; dreq.divisor = ga_reg; end
                    endcase
                end
            end
            else if (drsp.done)
            begin
                dwait_next = 1'b0;
                case (gph_reg)
                    2'd0:
                    begin
                        ga_next = gb_reg;
                        gb_next = drsp.rem;
                    end
                    2'd1:
                    begin
                        rn_next  = sn[63] ? 64'd0 - drsp.quot : drsp.quot;
                        gph_next = 2'd2;
                    end
                    default:
                    begin
                        red_done = 1'b1;
                        red_n = rn_next;
                        red_d = drsp.quot;
                        rd_next = drsp.quot;
                        gph_next = 2'd0;
                    end
                endcase
            end
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    op_next = in_ch.operation;
                    an_next = sext(in_ch.a_num);
                    ad_next = sext(in_ch.a_den);
                    bn_next = sext(in_ch.b_num);
                    bd_next = sext(in_ch.b_den);
                    ip_next = 64'd0; rel_next = REL_LT; err_next = ERR_OK;
                    rn_next = 64'd0; rd_next = 64'd1;
                    st_next = ST_CHECK;
                    gph_next = 2'd0; dwait_next = 1'b0; ov_next = 1'b0;
                end
            end
            ST_CHECK:
            begin
                // operand validity; set up A reduction
                if (op_reg == OP_NOP)
                    st_next = ST_OUT;
                else if (ad_reg == 64'd0 || (ad_reg[63] && op_reg != OP_NORM) ||
                         (op_reg != OP_NORM && op_reg != OP_SPLIT &&
                          (bd_reg == 64'd0 || bd_reg[63])))
                begin
                    err_next = ERR_ZERO;
                    st_next = ST_OUT;
                end
                else
                begin
                    if (ad_reg[63])
                    begin
                        an_next = 64'd0 - an_reg;
                        ad_next = 64'd0 - ad_reg;
                    end
                    ga_next = mag(ad_reg[63] ? 64'd0 - an_reg : an_reg);
                    gb_next = mag(ad_reg);
                    st_next = ST_RED_A;
                end
            end
            ST_RED_A:
            begin
                if (red_done)
                begin
                    an_next = red_n; ad_next = red_d;
                    if (op_reg == OP_NORM || op_reg == OP_SPLIT)
                        st_next = ST_PREP;
                    else
                    begin
                        ga_next = mag(bn_reg); gb_next = bd_reg;
                        st_next = ST_RED_B;
                    end
                end
            end
            ST_RED_B:
            begin
                if (red_done)
                begin
                    bn_next = red_n; bd_next = red_d;
                    st_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                // first product: an*bd (or an*bn for multiply)
                mul_a = an_reg[31:0];
                mul_b = (op_reg == OP_MUL) ? bn_reg[31:0] : bd_reg[31:0];
                rn_next = mul_p;
                st_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                // second product: bn*ad (or ad*bd for multiply), held in rd
                mul_a = (op_reg == OP_MUL) ? ad_reg[31:0] : bn_reg[31:0];
                mul_b = (op_reg == OP_MUL) ? bd_reg[31:0] : ad_reg[31:0];
                rd_next = mul_p;
                st_next = ST_PREP;
            end
            ST_PREP:
            begin
                st_next = ST_RED_R;
                case (op_reg)
                    OP_NORM: begin rn_next = an_reg; rd_next = ad_reg; end
                    OP_ADD:  begin rn_next = rn_reg + rd_reg; mul_a = ad_reg[31:0];
                                   mul_b = bd_reg[31:0]; rd_next = mul_p; end
                    OP_SUB:  begin rn_next = rn_reg - rd_reg; mul_a = ad_reg[31:0];
                                   mul_b = bd_reg[31:0]; rd_next = mul_p; end
                    OP_MUL:  ;
                    OP_DIV:
                    begin
                        // rn = an*bd, rd = bn*ad
                        if (bn_reg == 64'd0)
                        begin
                            err_next = ERR_ZERO;
                            st_next = ST_OUT;
                        end
                        else if (bn_reg[63])
                        begin
                            rn_next = 64'd0 - rn_reg;
                            rd_next = 64'd0 - rd_reg;
                        end
                    end
                    OP_CMP:
                    begin
                        if ($signed(rn_reg) < $signed(rd_reg)) rel_next = REL_LT;
                        else if (rn_reg == rd_reg) rel_next = REL_EQ;
                        else rel_next = REL_GT;
                        rn_next = 64'd0; rd_next = 64'd1;
                        st_next = ST_OUT;
                    end
                    default:
                    begin
                        // split: divide |an| by ad
                        st_next = ST_SPLIT;
                        rd_next = ad_reg;
                    end
                endcase
                if (st_next == ST_RED_R)
                begin
                    ga_next = mag(rn_next); gb_next = rd_next;
                    gph_next = 2'd0;
                end
            end
            ST_SPLIT:
            begin
                if (!dwait_reg)
                begin
                    dwait_next = 1'b1;
                    dreq.start = 1'b1;
                    dreq.dividend = mag(an_reg);
                    dreq.divisor = ad_reg;
                end
                else if (drsp.done)
                begin
                    dwait_next = 1'b0;
                    ip_next = an_reg[63] ? 64'd0 - drsp.quot : drsp.quot;
                    rn_next = an_reg[63] ? 64'd0 - drsp.rem : drsp.rem;
                    ga_next = drsp.rem; gb_next = ad_reg;
                    gph_next = 2'd0;
                    st_next = ST_RED_R;
                end
            end
            ST_RED_R:
            begin
                if (red_done)
                begin
                    if ($signed(red_n) > $signed(wmax) ||
                        $signed(red_n) < $signed(64'd0 - wmax - 64'd1) ||
                        red_d > wmax ||
                        $signed(ip_reg) > $signed(wmax) ||
                        $signed(ip_reg) < $signed(64'd0 - wmax - 64'd1))
                        err_next = ERR_OVF;
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    if (err_reg != ERR_OK)
                    begin
                        o_num_next = 32'd0; o_den_next = 31'd1; o_ip_next = 32'd0;
                        rel_next = REL_LT;
                    end
                    else
                    begin
                        o_num_next = rn_reg[31:0];
                        o_den_next = rd_reg[30:0];
                        o_ip_next  = ip_reg[31:0];
                    end
                end
                else if (out_ch.ready)
                begin
                    ov_next = 1'b0;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            dwait_reg <= 1'b0;
            gph_reg   <= 2'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            dwait_reg <= dwait_next;
            gph_reg   <= gph_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        an_reg <= an_next; ad_reg <= ad_next; bn_reg <= bn_next; bd_reg <= bd_next;
        rn_reg <= rn_next; rd_reg <= rd_next; ip_reg <= ip_next;
        ga_reg <= ga_next; gb_reg <= gb_next;
        err_reg <= err_next; rel_reg <= rel_next;
        o_num_reg <= o_num_next; o_den_reg <= o_den_next; o_ip_reg <= o_ip_next;
    end

    assign in_ch.ready       = (st_reg == ST_IDLE);
    assign out_ch.valid      = (st_reg == ST_OUT) && ov_reg;
    assign out_ch.res_num    = o_num_reg;
    assign out_ch.res_den    = o_den_reg;
    assign out_ch.int_part   = o_ip_reg;
    assign out_ch.relation   = rel_reg;
    assign out_ch.error_code = err_reg;
endmodule
`default_nettype wire

>>> design/rau_div.sv
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div
    import rau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        shifted   = {r_reg, q_reg[63]};
        trial     = shifted - {1'b0, d_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            q_next    = req.dividend;
            r_next    = 64'd0;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = shifted[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;
endmodule
`default_nettype wire

>>> sim/rau_tb_if.sv
`default_nettype none
// Monitor-side flag for accepted output words; the design's own interfaces carry the wires.
interface rau_tb_probe (input wire logic clk);
    timeunit 1ns;
    timeprecision 1ps;
    logic seen;
endinterface
`default_nettype wire

>>> sim/rational_arith_unit_core_tb.sv
`default_nettype none
module rational_arith_unit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    localparam int WB = 32;
    localparam longint WMAXL = 64'sd2147483647;
    localparam longint WMINL = -64'sd2147483648;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
    } rat_word_t;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [31:0] ip;
        logic [1:0]  rel;
        logic [1:0]  err;
    } rat_res_t;

    // directed row: word plus an optional typed-in answer
    typedef struct {
        rat_word_t w;
        bit        fixed;
        rat_res_t  r;
    } vec_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();
    rau_tb_probe i_probe (.clk(clk));

    rational_arith_unit_core #(.WORD_BITS(WB)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #4 clk = ~clk;

    rat_res_t  pending_res[$];
    int        n_bad = 0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;

    // ---------------- predictor ----------------
    function automatic longint gcd_u(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return (a != 0) ? longint'(a) : 1;
    endfunction

    function automatic longint absl(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // canonical form; returns 0 when the denominator is not acceptable
    function automatic bit canon(longint n, longint d, bit allow_neg,
                                 output longint on, output longint od);
        longint g;
        on = 0;
        od = 1;
        if (d == 0 || (d < 0 && !allow_neg))
            return 1'b0;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        g = gcd_u(absl(n), d);
        on = n / g;
        od = d / g;
        return 1'b1;
    endfunction

    function automatic rat_res_t rat_predict(rat_word_t w);
        rat_res_t r;
        longint an, ad, bn, bd, rn, rd, ip, l, rr, g;
        bit ok_a, ok_b;
        logic [1:0] err;
        logic [1:0] rel;
        rn = 0; rd = 1; ip = 0; rel = REL_LT; err = ERR_OK;
        ok_a = canon(longint'(signed'(w.an)), longint'(signed'(w.ad)), w.op == OP_NORM, an, ad);
        ok_b = canon(longint'(signed'(w.bn)), longint'(signed'(w.bd)), 1'b0, bn, bd);
        if (w.op == OP_NOP)
        begin
        end
        else if (!ok_a || (w.op >= OP_ADD && w.op <= OP_CMP && !ok_b))
            err = ERR_ZERO;
        else
        begin
            case (w.op)
                OP_NORM:  begin rn = an; rd = ad; end
                OP_ADD:   begin rn = an * bd + bn * ad; rd = ad * bd; end
                OP_SUB:   begin rn = an * bd - bn * ad; rd = ad * bd; end
                OP_MUL:   begin rn = an * bn; rd = ad * bd; end
                OP_DIV:
                begin
                    if (bn == 0)
                        err = ERR_ZERO;
                    else if (bn < 0)
                    begin
                        rn = -(an * bd); rd = ad * -bn;
                    end
                    else
                    begin
                        rn = an * bd; rd = ad * bn;
                    end
                end
                OP_CMP:
                begin
                    l = an * bd;
                    rr = bn * ad;
                    rel = (l < rr) ? REL_LT : ((l == rr) ? REL_EQ : REL_GT);
                end
                default:
                begin
                    ip = an / ad;
                    rn = an % ad;
                    rd = ad;
                end
            endcase
            if (err == ERR_OK)
            begin
                g = gcd_u(absl(rn), rd);
                rn = rn / g;
                rd = rd / g;
                if (rn < WMINL || rn > WMAXL || rd > WMAXL || ip < WMINL || ip > WMAXL)
                    err = ERR_OVF;
            end
        end
        if (err != ERR_OK)
        begin
            rn = 0; rd = 1; ip = 0; rel = REL_LT;
        end
        r.num = rn[31:0];
        r.den = rd[30:0];
        r.ip  = ip[31:0];
        r.rel = rel;
        r.err = err;
        return r;
    endfunction

    // ---------------- output side: ready and checking ----------------
    initial
    begin
        out_ch.ready = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_NOP;
        in_ch.a_num = '0;
        in_ch.a_den = 32'd1;
        in_ch.b_num = '0;
        in_ch.b_den = 32'd1;
        i_probe.seen = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        rat_res_t got;
        rat_res_t exp_r;
        i_probe.seen <= rst_n && out_ch.valid && out_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.res_num, out_ch.res_den, out_ch.int_part,
                    out_ch.relation, out_ch.error_code};
            if (pending_res.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result word %h", got);
            end
            else
            begin
                exp_r = pending_res.pop_front();
                if (got !== exp_r)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: num %h/%h den %h/%h ip %h/%h rel %0d/%0d err %0d/%0d",
                                 exp_r.num, got.num, exp_r.den, got.den, exp_r.ip, got.ip,
                                 exp_r.rel, got.rel, exp_r.err, got.err);
                end
            end
        end
    end

    // ---------------- input side ----------------
    // Queue expectation and hold valid until the unit is ready again; valid drops only while idling.
    task automatic send_word(rat_word_t w, bit fixed, rat_res_t fixed_r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= w.op;
        in_ch.a_num     <= w.an;
        in_ch.a_den     <= w.ad;
        in_ch.b_num     <= w.bn;
        in_ch.b_den     <= w.bd;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_res.push_back(fixed ? fixed_r : rat_predict(w));
    endtask

    // Operand mix: small values reduce quickly, some full-width extremes.
    function automatic logic [31:0] pick_val(bit nonneg);
        logic [31:0] v;
        case ($urandom_range(9))
            0:       v = $urandom;
            1:       v = 32'h7fffffff - $urandom_range(3);
            2:       v = 32'h80000000 + $urandom_range(3);
            3, 4:    v = $urandom_range(65535);
            default: v = $urandom_range(200);
        endcase
        if (!nonneg && $urandom_range(1))
            v = -v;
        return v;
    endfunction

    function automatic rat_word_t rand_word();
        rat_word_t w;
        w.op = ($urandom_range(49) == 0) ? OP_NOP : 3'($urandom_range(6));
        w.an = pick_val(1'b0);
        w.bn = pick_val(1'b0);
        w.ad = pick_val(1'b1);
        w.bd = pick_val(1'b1);
        // mostly valid denominators, some zero or negative
        case ($urandom_range(19))
            0:       w.ad = 32'd0;
            1:       w.bd = 32'd0;
            2:       w.ad = -w.ad;
            3:       w.bd = -w.bd;
            default: ;
        endcase
        if (w.ad == 32'h80000000 && w.op != OP_NORM)
            w.ad = 32'h7fffffff;
        if (w.bd == 32'h80000000)
            w.bd = 32'h7fffffff;
        return w;
    endfunction

    vec_row_t dir_tab[$];

    task automatic add_row(logic [2:0] op, int an, int ad, int bn, int bd,
                           bit fixed = 0, rat_res_t r = '0);
        vec_row_t row;
        row.w = '{op, an, ad, bn, bd};
        row.fixed = fixed;
        row.r = r;
        dir_tab.push_back(row);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_res.size() != 0 || i_probe.seen)
            @(posedge clk);
    endtask

    initial
    begin
        rat_word_t w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every operation, error paths, extremes
        add_row(OP_NORM, 6, -4, 0, 1);
        add_row(OP_NORM, 0, -5, 0, 1, 1, '{32'd0, 31'd1, 32'd0, REL_LT, ERR_OK});
        add_row(OP_NORM, 32'h80000000, -1, 0, 1, 1, '{32'd0, 31'd1, 32'd0, REL_LT, ERR_OVF});
        add_row(OP_NORM, 3, 0, 0, 1, 1, '{32'd0, 31'd1, 32'd0, REL_LT, ERR_ZERO});
        add_row(OP_ADD, 1, 2, 1, 3);
        add_row(OP_ADD, 1, -2, 1, 3, 1, '{32'd0, 31'd1, 32'd0, REL_LT, ERR_ZERO});
        add_row(OP_ADD, 1, 2, 1, 0, 1, '{32'd0, 31'd1, 32'd0, REL_LT, ERR_ZERO});
        add_row(OP_ADD, 32'h7fffffff, 1, 1, 1, 1, '{32'd0, 31'd1, 32'd0, REL_LT, ERR_OVF});
        add_row(OP_SUB, 32'h80000000, 1, 1, 1, 1, '{32'd0, 31'd1, 32'd0, REL_LT, ERR_OVF});
        add_row(OP_SUB, 5, 6, 1, 6);
        add_row(OP_MUL, 32'h7fffffff, 3, 3, 32'h7fffffff);
        add_row(OP_MUL, 1, 32'h7fffffff, 1, 2);
        add_row(OP_DIV, 3, 4, -3, 8);
        add_row(OP_DIV, 3, 4, 0, 8, 1, '{32'd0, 31'd1, 32'd0, REL_LT, ERR_ZERO});
        add_row(OP_CMP, 1, 3, 2, 6, 1, '{32'd0, 31'd1, 32'd0, REL_EQ, ERR_OK});
        add_row(OP_CMP, -1, 3, 1, 3, 1, '{32'd0, 31'd1, 32'd0, REL_LT, ERR_OK});
        add_row(OP_CMP, 32'h7fffffff, 1, 32'h80000000, 1);
        add_row(OP_SPLIT, -7, 2, 0, 0);
        add_row(OP_SPLIT, 32'h80000000, 1, 5, -1);
        add_row(OP_SPLIT, 9, 6, 1, 1);
        add_row(OP_NOP, 1, 0, 1, 0, 1, '{32'd0, 31'd1, 32'd0, REL_LT, ERR_OK});
        add_row(OP_NORM, 32'hffffffff, 32'h80000000, 0, 1);

        foreach (dir_tab[i])
            send_word(dir_tab[i].w, dir_tab[i].fixed, dir_tab[i].r);

        // random, three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 35 : ((ph == 1) ? 79 : 0);
            snk_idle_pct = (ph == 0) ? 79 : ((ph == 1) ? 35 : 0);
            for (int k = 0; k < 345; k++)
            begin
                if (k == 100)
                    drain();    // hold off until the unit is empty
                w = rand_word();
                send_word(w, 1'b0, '0);
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (n_bad == 0)
            $display("rational_arith_unit_core_tb: done, clean");
        else
            $display("rational_arith_unit_core_tb: done, errors");
        $finish;
    end

    // watchdog: ~1060 words, some of them with long Euclid chains
    initial
    begin
        #(64'd400_000_000);
        $display("rational_arith_unit_core_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
design/rau_pkg.sv
design/rau_if.sv
design/rau_div.sv
design/rational_arith_unit_core.sv
sim/rau_tb_if.sv
sim/rational_arith_unit_core_tb.sv
